[hdl/fqks_pkg.sv]
// Shared types and constants for the FASTQ k-mer splitter.
package fqks_pkg;

   localparam int KLEN_W   = 6;
   localparam int PLEN_W   = 5;
   localparam int CSR_W    = 6;
   localparam int CSR_IX_W = 1;
   localparam int PREFIX_W = 32;
   localparam int SUFFIX_W = 62;
   localparam int RECORD_W = 32;

   localparam logic [CSR_IX_W-1:0] CSR_KMER_LEN   = 1'b0;
   localparam logic [CSR_IX_W-1:0] CSR_PREFIX_LEN = 1'b1;

   localparam logic [KLEN_W-1:0] KMER_LEN_RESET   = 6'd31;
   localparam logic [PLEN_W-1:0] PREFIX_LEN_RESET = 5'd5;

   localparam logic [7:0] CHAR_NL   = 8'h0A;
   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_VT   = 8'h0B;
   localparam logic [7:0] CHAR_FF   = 8'h0C;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_AT   = 8'h40;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_T    = 8'h54;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   localparam logic KIND_KMER = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [4:0] {
      PH_HEADER    = 5'b00001,
      PH_SEQUENCE  = 5'b00010,
      PH_SEPARATOR = 5'b00100,
      PH_QUALITY   = 5'b01000,
      PH_BETWEEN   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       shift;
      logic       clear;
      logic [1:0] code;
      logic       amb;
   } win_ctrl_type;

   typedef struct packed {
      logic                emit;
      logic [PREFIX_W-1:0] prefix;
      logic [SUFFIX_W-1:0] suffix;
      logic                ambiguous;
   } kmer_type;

endpackage

[hdl/fqks_window.sv]
// Sliding base window with k-mer extraction and prefix/suffix split.
module fqks_window #(
   parameter int MAX_KMER = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fqks_pkg::win_ctrl_type        ctrl,
   input  logic [fqks_pkg::KLEN_W-1:0]   kmer_len,
   input  logic [fqks_pkg::PLEN_W-1:0]   prefix_len,
   output fqks_pkg::kmer_type            kmer
);

   localparam int WIN_W  = 2 * MAX_KMER;
   localparam int FILL_W = $clog2(MAX_KMER + 1);
   localparam int KW     = fqks_pkg::KLEN_W;
   localparam logic [KW-1:0]     MAX_K    = KW'(MAX_KMER);
   localparam logic [FILL_W-1:0] FILL_TOP = FILL_W'(MAX_KMER);

   logic [WIN_W-1:0]    win_ff, win_in, win_new, kmer_bits;
   logic [MAX_KMER-1:0] amb_ff, amb_in, amb_new;
   logic [FILL_W-1:0]   fill_ff, fill_in, fill_new;
   logic [KW-1:0]       k_eff, p_eff, s_eff;
   logic [KW:0]         k2, s2;

   always_comb begin
      win_new  = {win_ff[WIN_W-3:0], ctrl.code};
      amb_new  = {amb_ff[MAX_KMER-2:0], ctrl.amb};
      fill_new = (fill_ff == FILL_TOP) ? fill_ff : fill_ff + 1'b1;

      // clamp lengths so the suffix always keeps at least one base
      if (kmer_len < KW'(2)) begin
         k_eff = KW'(2);
      end else if (kmer_len > MAX_K) begin
         k_eff = MAX_K;
      end else begin
         k_eff = kmer_len;
      end
      p_eff = (prefix_len == '0) ? KW'(1) : KW'(prefix_len);
      if (p_eff > k_eff - 1'b1) begin
         p_eff = k_eff - 1'b1;
      end
      s_eff = k_eff - p_eff;
      k2    = {k_eff, 1'b0};
      s2    = {s_eff, 1'b0};

      kmer_bits      = win_new & ~({WIN_W{1'b1}} << k2);
      kmer.emit      = ctrl.shift && (KW'(fill_new) >= k_eff);
      kmer.prefix    = fqks_pkg::PREFIX_W'(kmer_bits >> s2);
      kmer.suffix    = fqks_pkg::SUFFIX_W'(kmer_bits & ~({WIN_W{1'b1}} << s2));
      kmer.ambiguous = |(amb_new & ~({MAX_KMER{1'b1}} << k_eff));

      win_in  = win_ff;
      amb_in  = amb_ff;
      fill_in = fill_ff;
      if (ctrl.clear) begin
         win_in  = '0;
         amb_in  = '0;
         fill_in = '0;
      end else if (ctrl.shift) begin
         win_in  = win_new;
         amb_in  = amb_new;
         fill_in = fill_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         amb_ff  <= '0;
         fill_ff <= '0;
      end else begin
         win_ff  <= win_in;
         amb_ff  <= amb_in;
         fill_ff <= fill_in;
      end
   end

endmodule

[hdl/fastq_record_kmer_splitter.sv]
// Top level: FASTQ parser, record counters and registered result port.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_text_byte
//   rsp      out        rsp_valid/rsp_stall  kind, prefix, suffix, flags, record
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One byte per cycle unless the result is stalled; a result is registered in the
// cycle after its byte. The single result register sets the pace: a new request
// is taken whenever the result register is empty or being drained.
// Reset is synchronous and returns the parser to the header phase.
// A stalled result holds req_stall high until it is taken.
module fastq_record_kmer_splitter #(
   parameter int MAX_KMER   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_text_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_result_kind,
   output logic [fqks_pkg::PREFIX_W-1:0]   rsp_prefix_bases,
   output logic [fqks_pkg::SUFFIX_W-1:0]   rsp_suffix_bases,
   output logic                            rsp_has_ambiguous,
   output logic                            rsp_length_mismatch,
   output logic [fqks_pkg::RECORD_W-1:0]   rsp_record_number,
   input  logic                            csr_write_enable,
   input  logic [fqks_pkg::CSR_IX_W-1:0]   csr_index,
   input  logic [fqks_pkg::CSR_W-1:0]      csr_write_data
);

   fqks_pkg::phase_type                 phase_ff, phase_in;
   logic                                prev_nl_ff;
   logic [COUNT_BITS-1:0]               base_cnt_ff, base_cnt_in;
   logic [COUNT_BITS-1:0]               qual_cnt_ff, qual_cnt_in;
   logic [fqks_pkg::RECORD_W-1:0]       record_ff, record_in;
   logic [fqks_pkg::KLEN_W-1:0]         kmer_len_ff;
   logic [fqks_pkg::PLEN_W-1:0]         prefix_len_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                kind_ff, amb_ff, mismatch_ff;
   logic [fqks_pkg::PREFIX_W-1:0]       prefix_ff;
   logic [fqks_pkg::SUFFIX_W-1:0]       suffix_ff;
   logic [fqks_pkg::RECORD_W-1:0]       rnum_ff;

   logic                                accept, nl, white, rec_end;
   fqks_pkg::win_ctrl_type              win_ctrl;
   fqks_pkg::kmer_type                  kmer;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign nl        = (req_text_byte == fqks_pkg::CHAR_NL);
   assign white     = nl || (req_text_byte == fqks_pkg::CHAR_SP)
                      || (req_text_byte == fqks_pkg::CHAR_TAB)
                      || (req_text_byte == fqks_pkg::CHAR_VT)
                      || (req_text_byte == fqks_pkg::CHAR_FF)
                      || (req_text_byte == fqks_pkg::CHAR_CR);

   always_comb begin
      phase_in      = phase_ff;
      base_cnt_in   = base_cnt_ff;
      qual_cnt_in   = qual_cnt_ff;
      record_in     = record_ff;
      rec_end       = 1'b0;
      win_ctrl      = '0;
      case (req_text_byte)
         fqks_pkg::CHAR_A: win_ctrl.code = fqks_pkg::CODE_A;
         fqks_pkg::CHAR_C: win_ctrl.code = fqks_pkg::CODE_C;
         fqks_pkg::CHAR_G: win_ctrl.code = fqks_pkg::CODE_G;
         fqks_pkg::CHAR_T: win_ctrl.code = fqks_pkg::CODE_T;
         default: begin
            win_ctrl.code = fqks_pkg::CODE_A;
            win_ctrl.amb  = 1'b1;
         end
      endcase

      if (accept) begin
         case (phase_ff)
            fqks_pkg::PH_HEADER: begin
               if (nl) begin
                  win_ctrl.clear = 1'b1;
                  base_cnt_in    = '0;
                  qual_cnt_in    = '0;
                  phase_in       = fqks_pkg::PH_SEQUENCE;
               end
            end
            fqks_pkg::PH_SEQUENCE: begin
               if (white) begin
                  phase_in = phase_ff;
               end else if (prev_nl_ff && req_text_byte == fqks_pkg::CHAR_PLUS) begin
                  phase_in = fqks_pkg::PH_SEPARATOR;
               end else begin
                  win_ctrl.shift = 1'b1;
                  if (base_cnt_ff != '1) begin
                     base_cnt_in = base_cnt_ff + 1'b1;
                  end
               end
            end
            fqks_pkg::PH_SEPARATOR: begin
               if (nl) begin
                  qual_cnt_in = '0;
                  phase_in    = fqks_pkg::PH_QUALITY;
               end
            end
            fqks_pkg::PH_QUALITY: begin
               if (nl) begin
                  rec_end   = 1'b1;
                  record_in = record_ff + 1'b1;
                  phase_in  = fqks_pkg::PH_BETWEEN;
               end else if (!white && qual_cnt_ff != '1) begin
                  qual_cnt_in = qual_cnt_ff + 1'b1;
               end
            end
            fqks_pkg::PH_BETWEEN: begin
               if (prev_nl_ff && req_text_byte == fqks_pkg::CHAR_AT) begin
                  phase_in = fqks_pkg::PH_HEADER;
               end
            end
            default: phase_in = fqks_pkg::PH_HEADER;
         endcase
      end

      if (rec_end || kmer.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   fqks_window #(
      .MAX_KMER (MAX_KMER)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .kmer_len   (kmer_len_ff),
      .prefix_len (prefix_len_ff),
      .kmer       (kmer)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= fqks_pkg::PH_HEADER;
         prev_nl_ff    <= 1'b1;
         base_cnt_ff   <= '0;
         qual_cnt_ff   <= '0;
         record_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         kmer_len_ff   <= fqks_pkg::KMER_LEN_RESET;
         prefix_len_ff <= fqks_pkg::PREFIX_LEN_RESET;
      end else begin
         phase_ff     <= phase_in;
         base_cnt_ff  <= base_cnt_in;
         qual_cnt_ff  <= qual_cnt_in;
         record_ff    <= record_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prev_nl_ff <= nl;
         end
         if (csr_write_enable) begin
            case (csr_index)
               fqks_pkg::CSR_KMER_LEN:
                  kmer_len_ff <= csr_write_data[fqks_pkg::KLEN_W-1:0];
               fqks_pkg::CSR_PREFIX_LEN:
                  prefix_len_ff <= csr_write_data[fqks_pkg::PLEN_W-1:0];
               default: kmer_len_ff <= kmer_len_ff;
            endcase
         end
      end
   end

   // load the result register only when a request produces a result
   always_ff @(posedge clock) begin
      if (rec_end) begin
         kind_ff     <= fqks_pkg::KIND_END;
         prefix_ff   <= '0;
         suffix_ff   <= '0;
         amb_ff      <= 1'b0;
         mismatch_ff <= (base_cnt_ff != qual_cnt_ff);
         rnum_ff     <= record_ff;
      end else if (kmer.emit) begin
         kind_ff     <= fqks_pkg::KIND_KMER;
         prefix_ff   <= kmer.prefix;
         suffix_ff   <= kmer.suffix;
         amb_ff      <= kmer.ambiguous;
         mismatch_ff <= 1'b0;
         rnum_ff     <= record_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_prefix_bases    = prefix_ff;
   assign rsp_suffix_bases    = suffix_ff;
   assign rsp_has_ambiguous   = amb_ff;
   assign rsp_length_mismatch = mismatch_ff;
   assign rsp_record_number   = rnum_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");

   a_quality_end_result: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == fqks_pkg::PH_QUALITY && nl
      |=> rsp_valid && rsp_result_kind == fqks_pkg::KIND_END)
      else $error("quality line end gave no record-end result");

   a_end_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == fqks_pkg::KIND_END
      |-> rsp_prefix_bases == '0 && rsp_suffix_bases == '0 && !rsp_has_ambiguous)
      else $error("record-end result carries base data");

   a_kmer_no_mismatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == fqks_pkg::KIND_KMER |-> !rsp_length_mismatch)
      else $error("k-mer result flags a length mismatch");

endmodule
